// ----- hw/rtl/utf16_to_cp1252_encoder_defines.svh -----
// assertion macros for the utf16 to cp1252 encoder
// no dependencies; included by the top level only
`ifndef UTF16_TO_CP1252_ENCODER_DEFINES_SVH
`define UTF16_TO_CP1252_ENCODER_DEFINES_SVH

// clocked assertion with synchronous active-low reset disable
`define U16CP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock i_clk and reset i_rst_n
`define U16CP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ----- hw/rtl/u16cp_pkg.sv -----
// shared types, constants and the reverse lookup for the utf16 to cp1252 encoder
// no dependencies
`default_nettype none

package u16cp_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
    localparam logic [15:0] C1_LO       = 16'h0080;
    localparam logic [15:0] LATIN_LO    = 16'h00A0;
    localparam logic [15:0] LATIN_HI    = 16'h00FF;
    localparam logic [7:0]  REPL_RESET  = 8'h3F;
    localparam logic [7:0]  HIGH_BASE   = 8'h80;

    localparam logic [15:0] HIGH_MAP [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    // one queued operation: an optional leading replacement byte, then one byte
    typedef struct packed {
        logic       two;
        logic [7:0] data;
        logic       rep;
        logic       eos;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       hit;
        logic [7:0] data;
    } t_lookup;

    function automatic t_lookup lookup_byte(input logic [15:0] u);
        t_lookup r;
        r.hit  = 1'b0;
        r.data = u[7:0];
        if (u < C1_LO || (u >= LATIN_LO && u <= LATIN_HI)) begin
            r.hit = 1'b1;
        end else begin
            for (int i = 0; i < 32; i++) begin
                if (HIGH_MAP[i] == u) begin
                    r.hit  = 1'b1;
                    r.data = HIGH_BASE | 8'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/u16cp_front.sv -----
// front end: accepts code units, tracks the held high surrogate, classifies
// depends on u16cp_pkg
`default_nettype none

module u16cp_front
    import u16cp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_end_of_string,
    input  wire logic [7:0]  i_repl,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_op              o_op
);

    logic    r_pending;
    logic    n_pending;
    logic    accept;
    logic    is_high;
    logic    is_low;
    logic    hold_new;
    logic    want_push;
    t_lookup lk;
    t_op     single;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_high    = i_code_unit >= HIGH_SUR_LO && i_code_unit <= HIGH_SUR_HI;
    assign is_low     = i_code_unit >= LOW_SUR_LO && i_code_unit <= LOW_SUR_HI;
    assign hold_new   = is_high && !i_end_of_string;
    assign lk         = lookup_byte(i_code_unit);

    always_comb begin
        single.two  = 1'b0;
        single.data = lk.hit ? lk.data : i_repl;
        single.rep  = !lk.hit;
        single.eos  = i_end_of_string;

        o_op      = single;
        want_push = 1'b1;
        n_pending = 1'b0;
        if (r_pending) begin
            if (is_low) begin
                // surrogate pair completes: one replacement
                o_op.data = i_repl;
                o_op.rep  = 1'b1;
            end else if (hold_new) begin
                // unpaired high replaced, new high held
                o_op.data = i_repl;
                o_op.rep  = 1'b1;
                o_op.eos  = 1'b0;
                n_pending = 1'b1;
            end else begin
                o_op.two = 1'b1;
            end
        end else if (hold_new) begin
            want_push = 1'b0;
            n_pending = 1'b1;
        end
    end

    assign o_push = accept && want_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/u16cp_queue.sv -----
// two-entry operation queue between the front and the back end
// depends on u16cp_pkg
`default_nettype none

module u16cp_queue
    import u16cp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_op   i_op,
    input  wire logic  i_pop,
    output t_op        o_head,
    output t_q_stat    o_stat
);

    t_op                r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == QCNT_W'(QDEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/u16cp_back.sv -----
// back end: expands queued operations into bytes, keeps the sticky replaced flag
// depends on u16cp_pkg
`default_nettype none

module u16cp_back
    import u16cp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_op        i_head,
    input  wire t_q_stat    i_q_stat,
    input  wire logic [7:0] i_repl,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item,
    output logic            o_last_of_string,
    output logic            o_any_replaced
);

    logic       r_valid;
    logic       r_second;
    logic       r_seen;
    logic [7:0] r_byte;
    logic       r_last_item;
    logic       r_last_str;
    logic       r_any;

    logic       load;
    logic       emit;
    logic [7:0] n_byte;
    logic       n_rep;
    logic       n_last_item;
    logic       n_last_str;
    logic       n_any;

    assign load = !r_valid || i_out_ready;
    assign emit = load && !i_q_stat.empty;

    always_comb begin
        if (!r_second && i_head.two) begin
            // leading replacement for an unpaired high surrogate
            n_byte      = i_repl;
            n_rep       = 1'b1;
            n_last_item = 1'b0;
            n_last_str  = 1'b0;
        end else begin
            n_byte      = i_head.data;
            n_rep       = i_head.rep;
            n_last_item = 1'b1;
            n_last_str  = i_head.eos;
        end
        n_any = r_seen || n_rep;
    end

    assign o_pop = emit && (r_second || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_seen   <= 1'b0;
        end else if (load) begin
            r_valid <= emit;
            if (emit) begin
                r_second <= !r_second && i_head.two;
                r_seen   <= n_last_str ? 1'b0 : n_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte      <= n_byte;
            r_last_item <= n_last_item;
            r_last_str  <= n_last_str;
            r_any       <= n_any;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last_of_item   = r_last_item;
    assign o_last_of_string = r_last_str;
    assign o_any_replaced   = r_any;

endmodule

`default_nettype wire

// ----- hw/rtl/utf16_to_cp1252_encoder.sv -----
// top level of the utf16 to cp1252 encoder: replacement register and assertions
// depends on u16cp_pkg, u16cp_front, u16cp_queue, u16cp_back and the defines header
//
// usage:
//   input channel (i_in_valid / o_in_ready) takes one utf16 code unit per transaction,
//   with i_end_of_string on the last unit of a string.
//   output channel (o_out_valid / i_out_ready) gives one cp1252 byte per transaction,
//   with last-of-item, last-of-string and the sticky any-replaced flag.
//   config channel (i_cfg_valid / o_cfg_ready) writes the replacement byte; always
//   ready, write only while the block is idle.
// path: an accepted code unit is written into the queue, then loaded into the output register.
// throughput: one code unit per cycle while the queue is not full; a unit other than a low
//   surrogate or a non-final high that follows a held high gives two bytes, a leading
//   replacement and then its own byte. a high surrogate not at string end gives no byte
//   until the next unit arrives.
// the rate is set by the single output register, fed from a two-entry queue.
// reset: clears the held surrogate, the replaced flag, the queue and the output;
//   the replacement byte returns to 0x3f.
// when the receiver stalls, the output register holds, the queue fills and
//   o_in_ready drops once two operations are waiting.
`default_nettype none
`include "utf16_to_cp1252_encoder_defines.svh"

module utf16_to_cp1252_encoder
    import u16cp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_end_of_string,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item,
    output logic             o_last_of_string,
    output logic             o_any_replaced,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0] r_repl;
    logic       push;
    logic       pop;
    t_op        op;
    t_op        head;
    t_q_stat    q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_repl <= i_cfg_data;
        end
    end

    u16cp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_repl          (r_repl),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_op            (op)
    );

    u16cp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (op),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    u16cp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_q_stat         (q_stat),
        .i_repl           (r_repl),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_item   (o_last_of_item),
        .o_last_of_string (o_last_of_string),
        .o_any_replaced   (o_any_replaced)
    );

    // string end only ever falls on the last byte of an item
    `U16CP_ASSERT(a_eos_on_item_end, o_out_valid && o_last_of_string |-> o_last_of_item, "last_of_string without last_of_item")
    // the leading byte of a two-byte item is always a replacement
    `U16CP_ASSERT(a_lead_is_repl, o_out_valid && !o_last_of_item |-> o_any_replaced, "leading byte not flagged as replaced")
    // queue status is consistent and never pops from empty
    `U16CP_ASSERT(a_queue_sane, !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty), "queue status inconsistent")

endmodule

`default_nettype wire
